// ----- design/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared widths, sizes, codes and control types.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int COEF_BITS  = 16;
  localparam int EXP_BITS   = 8;
  localparam int SUM_BITS   = COEF_BITS + 1;
  localparam int ADDR_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int IN_DATA_W  = ((COEF_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_BITS + EXP_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_ADD         = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } buf_wr_t;

endpackage

// ----- design/spa_term_buf.sv -----
// ----------------------------------------------------------------------------
// Term buffer
// One polynomial's coefficients and exponents, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module spa_term_buf (
  input  logic                                clk,
  input  spa_pkg::buf_wr_t                    wr,
  input  logic signed [spa_pkg::COEF_BITS-1:0] wr_coef,
  input  logic [spa_pkg::EXP_BITS-1:0]        wr_exp,
  input  logic [spa_pkg::ADDR_W-1:0]          rd_addr,
  output logic signed [spa_pkg::COEF_BITS-1:0] rd_coef,
  output logic [spa_pkg::EXP_BITS-1:0]        rd_exp
);

  logic [spa_pkg::COEF_BITS+spa_pkg::EXP_BITS-1:0] mem [spa_pkg::MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr_exp, wr_coef};
    end
    {rd_exp, rd_coef} <= mem[rd_addr];
  end

endmodule

// ----- design/spa_merge_ctrl.sv -----
// ----------------------------------------------------------------------------
// Merge sequencer
// Counts loads, walks both buffers with one shared compare and add unit,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module spa_merge_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [1:0]                           action,
  output spa_pkg::buf_wr_t                     wr_first,
  output spa_pkg::buf_wr_t                     wr_second,
  output logic [spa_pkg::ADDR_W-1:0]           rd_i,
  output logic [spa_pkg::ADDR_W-1:0]           rd_j,
  input  logic signed [spa_pkg::COEF_BITS-1:0] a_coef,
  input  logic [spa_pkg::EXP_BITS-1:0]         a_exp,
  input  logic signed [spa_pkg::COEF_BITS-1:0] b_coef,
  input  logic [spa_pkg::EXP_BITS-1:0]         b_exp,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic signed [spa_pkg::SUM_BITS-1:0]  sum_coefficient,
  output logic [spa_pkg::EXP_BITS-1:0]         term_exponent,
  output logic                                 last_term,
  output logic                                 no_terms,
  output logic                                 terms_dropped
);

  spa_pkg::state_t           state, state_next;
  logic [spa_pkg::CNT_W-1:0] first_count, first_count_next;
  logic [spa_pkg::CNT_W-1:0] second_count, second_count_next;
  logic                      overflow_flag, overflow_flag_next;
  logic [spa_pkg::CNT_W-1:0] idx_i, idx_i_next;
  logic [spa_pkg::CNT_W-1:0] idx_j, idx_j_next;
  logic                      out_free;
  logic                      load_out;
  logic                      a_v, b_v, take_a, take_b, use_a, use_b;
  logic signed [spa_pkg::SUM_BITS-1:0] op_a, op_b, sum;
  logic [spa_pkg::EXP_BITS-1:0]        merged_exp;
  logic [spa_pkg::CNT_W-1:0]           step_i, step_j;
  logic                                merge_last;
  logic                                set_empty;

  assign out_free = !m_tvalid || m_tready;
  assign rd_i     = idx_i[spa_pkg::ADDR_W-1:0];
  assign rd_j     = idx_j[spa_pkg::ADDR_W-1:0];
  assign s_tready = (state == spa_pkg::ST_IDLE);

  // shared compare and add unit
  always_comb begin
    a_v        = idx_i < first_count;
    b_v        = idx_j < second_count;
    take_a     = a_v && (!b_v || (a_exp > b_exp));
    take_b     = b_v && (!a_v || (a_exp < b_exp));
    use_a      = take_a || (a_v && b_v && (a_exp == b_exp));
    use_b      = take_b || (a_v && b_v && (a_exp == b_exp));
    op_a       = use_a ? {a_coef[spa_pkg::COEF_BITS-1], a_coef} : '0;
    op_b       = use_b ? {b_coef[spa_pkg::COEF_BITS-1], b_coef} : '0;
    sum        = op_a + op_b;
    merged_exp = take_b ? b_exp : a_exp;
    step_i     = idx_i + spa_pkg::CNT_W'(use_a);
    step_j     = idx_j + spa_pkg::CNT_W'(use_b);
    merge_last = (step_i >= first_count) && (step_j >= second_count);
  end

  always_comb begin
    state_next         = state;
    first_count_next   = first_count;
    second_count_next  = second_count;
    overflow_flag_next = overflow_flag;
    idx_i_next         = idx_i;
    idx_j_next         = idx_j;
    wr_first           = '0;
    wr_second          = '0;
    load_out           = 1'b0;
    set_empty          = 1'b0;
    wr_first.addr      = first_count[spa_pkg::ADDR_W-1:0];
    wr_second.addr     = second_count[spa_pkg::ADDR_W-1:0];
    case (state)
      spa_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (action)
            spa_pkg::ACT_LOAD_FIRST: begin
              if (first_count < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                wr_first.en      = 1'b1;
                first_count_next = first_count + spa_pkg::CNT_W'(1);
              end else begin
                overflow_flag_next = 1'b1;
              end
            end
            spa_pkg::ACT_LOAD_SECOND: begin
              if (second_count < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                wr_second.en      = 1'b1;
                second_count_next = second_count + spa_pkg::CNT_W'(1);
              end else begin
                overflow_flag_next = 1'b1;
              end
            end
            spa_pkg::ACT_ADD: begin
              idx_i_next = '0;
              idx_j_next = '0;
              if (first_count == '0 && second_count == '0) begin
                state_next = spa_pkg::ST_EMPTY;
              end else begin
                state_next = spa_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spa_pkg::ST_READ: begin
        state_next = spa_pkg::ST_EMIT;
      end
      spa_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          idx_i_next = step_i;
          idx_j_next = step_j;
          if (merge_last) begin
            first_count_next   = '0;
            second_count_next  = '0;
            overflow_flag_next = 1'b0;
            state_next         = spa_pkg::ST_IDLE;
          end else begin
            state_next = spa_pkg::ST_READ;
          end
        end
      end
      spa_pkg::ST_EMPTY: begin
        if (out_free) begin
          load_out           = 1'b1;
          set_empty          = 1'b1;
          overflow_flag_next = 1'b0;
          state_next         = spa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spa_pkg::ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      idx_i         <= '0;
      idx_j         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      first_count   <= first_count_next;
      second_count  <= second_count_next;
      overflow_flag <= overflow_flag_next;
      idx_i         <= idx_i_next;
      idx_j         <= idx_j_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum_coefficient <= set_empty ? '0 : sum;
      term_exponent   <= set_empty ? '0 : merged_exp;
      last_term       <= set_empty || merge_last;
      no_terms        <= set_empty;
      terms_dropped   <= overflow_flag;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    first_count <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)
    && second_count <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS))
    else $error("term count beyond capacity");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::ST_READ || state == spa_pkg::ST_EMIT)
    |-> (idx_i <= first_count && idx_j <= second_count
         && (idx_i < first_count || idx_j < second_count)))
    else $error("merge index past end of buffer");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::ST_EMIT && load_out && merge_last)
    |=> (first_count == '0 && second_count == '0 && !overflow_flag))
    else $error("counts not cleared after final term");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == spa_pkg::ST_EMIT
                         || $past(state) == spa_pkg::ST_EMPTY))
    else $error("result raised outside an emit state");
`endif

endmodule

// ----- design/sparse_polynomial_adder_unit.sv -----
// Sequence: a load writes its term into a buffer; an add reads both buffers in ST_READ,
//   then compares, adds and registers a term in ST_EMIT (ST_EMPTY for two empty buffers).
// Each result term takes a buffer read, then a compare and add, and waits while the output
//   is held; the input is stalled until an add's last term is registered; one load a cycle.
// Reset: synchronous, active high; clears both term counts, the overflow flag,
//   the sequencer and the output valid. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Loads terms of two polynomials and merges them in descending exponent
// order, summing terms of equal exponent.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]    s_tdata,  // coefficient, exponent
  input  logic [1:0]                       s_tuser,  // action
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0]   m_tdata,  // sum_coefficient, term_exponent
  output logic                             m_tlast,
  output logic [1:0]                       m_tuser   // no_terms, terms_dropped
);

  spa_pkg::buf_wr_t                     wr_first, wr_second;
  logic [spa_pkg::ADDR_W-1:0]           rd_i, rd_j;
  logic signed [spa_pkg::COEF_BITS-1:0] coefficient;
  logic [spa_pkg::EXP_BITS-1:0]         exponent;
  logic signed [spa_pkg::COEF_BITS-1:0] a_coef, b_coef;
  logic [spa_pkg::EXP_BITS-1:0]         a_exp, b_exp;
  logic signed [spa_pkg::SUM_BITS-1:0]  sum_coefficient;
  logic [spa_pkg::EXP_BITS-1:0]         term_exponent;
  logic                                 no_terms, terms_dropped;

  assign coefficient = s_tdata[spa_pkg::COEF_BITS-1:0];
  assign exponent    = s_tdata[spa_pkg::COEF_BITS+spa_pkg::EXP_BITS-1:spa_pkg::COEF_BITS];
  assign m_tdata     = spa_pkg::OUT_DATA_W'({term_exponent, sum_coefficient});
  assign m_tuser     = {terms_dropped, no_terms};

  spa_term_buf u_first (
    .clk     (clk),
    .wr      (wr_first),
    .wr_coef (coefficient),
    .wr_exp  (exponent),
    .rd_addr (rd_i),
    .rd_coef (a_coef),
    .rd_exp  (a_exp)
  );

  spa_term_buf u_second (
    .clk     (clk),
    .wr      (wr_second),
    .wr_coef (coefficient),
    .wr_exp  (exponent),
    .rd_addr (rd_j),
    .rd_coef (b_coef),
    .rd_exp  (b_exp)
  );

  spa_merge_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .action          (s_tuser),
    .wr_first        (wr_first),
    .wr_second       (wr_second),
    .rd_i            (rd_i),
    .rd_j            (rd_j),
    .a_coef          (a_coef),
    .a_exp           (a_exp),
    .b_coef          (b_coef),
    .b_exp           (b_exp),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .sum_coefficient (sum_coefficient),
    .term_exponent   (term_exponent),
    .last_term       (m_tlast),
    .no_terms        (no_terms),
    .terms_dropped   (terms_dropped)
  );

endmodule
